### rtl/pffe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pffe_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 8;
    localparam int PROD_W      = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_FADE_IN  = 2'd0;
    localparam logic [1:0] REG_FADE_OUT = 2'd1;
    localparam logic [1:0] REG_TAIL     = 2'd2;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_SCALE = 2'd1,
        MODE_TAIL  = 2'd2,
        MODE_DROP  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [6:0] ramp_frames;
        logic [4:0] fade_out_steps;
        logic [7:0] tail_samples;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          num;
        logic [GAIN_W-1:0]          den;
        logic                       scale;
        logic                       last;
    } entry_t;

endpackage

`default_nettype wire

### rtl/pffe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pffe_front
    import pffe_pkg::*;
#(
    parameter int FRAME_SAMPLES = 160
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cfg_t                       cfg,
    input  wire logic                       accept,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [7:0]                 frame_len,
    input  wire logic                       final_frame,
    input  wire logic                       round_start,
    input  wire logic                       later_round,
    input  wire logic                       stop_request,
    output logic                            push,
    output entry_t                          push_entry
);

    localparam int LEN_W = $clog2(FRAME_SAMPLES + 1);
    localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    mode_t            mode_reg, mode_next;
    logic [6:0]       fil_reg, fil_next;
    logic [6:0]       in_div_reg, in_div_next;
    logic             fading_reg, fading_next;
    logic [4:0]       fol_reg, fol_next;
    logic [4:0]       out_div_reg, out_div_next;
    logic             halted_reg, halted_next;
    logic [6:0]       num_reg, num_next;
    logic [6:0]       den_reg, den_next;

    logic [LEN_W-1:0] pos1;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_c;
    logic [CMP_W-1:0] flen;
    logic [CMP_W-1:0] k_ext;
    logic [LEN_W-1:0] k;
    logic             last;

    always_comb begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        mode_next    = mode_reg;
        fil_next     = fil_reg;
        in_div_next  = in_div_reg;
        fading_next  = fading_reg;
        fol_next     = fol_reg;
        out_div_next = out_div_reg;
        halted_next  = halted_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        pos1         = pos_reg;
        len_ext      = CMP_W'(frame_len);
        len_c        = len_ext;
        flen         = '0;
        k_ext        = '0;
        k            = '0;
        last         = 1'b0;
        push         = 1'b0;
        push_entry   = '{sample: sample, num: '0, den: '0, scale: 1'b0, last: 1'b0};

        if (accept) begin
            // new round: clear stop state, arm fade-in
            if (round_start) begin
                halted_next = 1'b0;
                fading_next = 1'b0;
                fol_next    = '0;
                pos1        = '0;
                in_div_next = cfg.ramp_frames;
                fil_next    = later_round ? cfg.ramp_frames : 7'd0;
            end

            // frame start: pick the mode for the whole frame
            if (pos1 == '0) begin
                if (len_ext == '0) begin
                    len_c = CMP_W'(1);
                end else if (len_ext > CMP_W'(FRAME_SAMPLES)) begin
                    len_c = CMP_W'(FRAME_SAMPLES);
                end
                len_next = LEN_W'(len_c);
                if (halted_next) begin
                    mode_next = MODE_DROP;
                end else begin
                    if (stop_request && !fading_next) begin
                        fading_next  = 1'b1;
                        out_div_next = cfg.fade_out_steps;
                        fol_next     = cfg.fade_out_steps;
                    end
                    if (fading_next && fol_next == '0) begin
                        halted_next = 1'b1;
                        mode_next   = MODE_DROP;
                    end else if (fading_next) begin
                        num_next  = 7'(fol_next);
                        den_next  = 7'(out_div_next);
                        fol_next  = fol_next - 5'd1;
                        mode_next = MODE_SCALE;
                    end else if (fil_next != '0) begin
                        num_next  = in_div_next - fil_next;
                        den_next  = in_div_next;
                        fil_next  = fil_next - 7'd1;
                        mode_next = MODE_SCALE;
                    end else if (final_frame) begin
                        mode_next = MODE_TAIL;
                    end else begin
                        mode_next = MODE_PASS;
                    end
                end
            end

            last     = (CMP_W'(pos1) + CMP_W'(1)) >= CMP_W'(len_next);
            pos_next = last ? '0 : pos1 + LEN_W'(1);

            k     = len_next - LEN_W'(1) - pos1;
            k_ext = CMP_W'(k);
            flen  = (CMP_W'(len_next) < CMP_W'(cfg.tail_samples)) ?
                    CMP_W'(len_next) : CMP_W'(cfg.tail_samples);

            push_entry.last = last;
            case (mode_next)
                MODE_DROP: begin
                    push = 1'b0;
                end
                MODE_SCALE: begin
                    push             = 1'b1;
                    push_entry.scale = 1'b1;
                    push_entry.num   = GAIN_W'(num_next);
                    push_entry.den   = GAIN_W'(den_next);
                end
                MODE_TAIL: begin
                    push = 1'b1;
                    if (k_ext < flen) begin
                        push_entry.scale = 1'b1;
                        push_entry.num   = GAIN_W'(k_ext);
                        push_entry.den   = GAIN_W'(flen);
                    end
                end
                default: begin
                    push = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            len_reg     <= LEN_W'(1);
            mode_reg    <= MODE_PASS;
            fil_reg     <= '0;
            in_div_reg  <= '0;
            fading_reg  <= 1'b0;
            fol_reg     <= '0;
            out_div_reg <= '0;
            halted_reg  <= 1'b0;
            num_reg     <= '0;
            den_reg     <= '0;
        end else begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            mode_reg    <= mode_next;
            fil_reg     <= fil_next;
            in_div_reg  <= in_div_next;
            fading_reg  <= fading_next;
            fol_reg     <= fol_next;
            out_div_reg <= out_div_next;
            halted_reg  <= halted_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pffe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pffe_queue
    import pffe_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        valid,
    output entry_t      pop_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/pffe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pffe_back
    import pffe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire entry_t               q_entry,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [SAMPLE_W-1:0]       m_sample,
    output logic                      m_last
);

    localparam int DIV_STEPS = PROD_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int REM_W     = GAIN_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    entry_t              ent_reg, ent_next;
    logic [PROD_W-1:0]   div_reg, div_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_sample_reg, m_sample_next;
    logic                m_last_reg, m_last_next;

    logic [SAMPLE_W-1:0] mag;
    logic [REM_W-1:0]    r1, r2;
    logic [REM_W-1:0]    d_ext;
    logic                b1, b2;
    logic [SAMPLE_W-1:0] q16;
    logic [SAMPLE_W-1:0] result;
    logic                out_free;

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_last   = m_last_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign mag      = ent_reg.sample[SAMPLE_W-1] ? (~ent_reg.sample + SAMPLE_W'(1))
                                                 : ent_reg.sample;
    assign d_ext    = REM_W'(ent_reg.den);
    assign q16      = div_reg[SAMPLE_W-1:0];

    always_comb begin
        // two restoring steps a cycle
        r1 = {rem_reg[REM_W-2:0], div_reg[PROD_W-1]};
        b1 = (r1 >= d_ext);
        if (b1) begin
            r1 = r1 - d_ext;
        end
        r2 = {r1[REM_W-2:0], div_reg[PROD_W-2]};
        b2 = (r2 >= d_ext);
        if (b2) begin
            r2 = r2 - d_ext;
        end
    end

    always_comb begin
        if (!ent_reg.scale) begin
            result = ent_reg.sample;
        end else if (ent_reg.den == '0) begin
            result = '0;
        end else if (neg_reg) begin
            result = ~q16 + SAMPLE_W'(1);
        end else begin
            result = q16;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ent_next      = ent_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_sample_next = m_sample_reg;
        m_last_next   = m_last_reg;
        q_pop         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ent_next   = q_entry;
                    state_next = q_entry.scale ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                div_next   = PROD_W'(mag) * PROD_W'(ent_reg.num);
                neg_next   = ent_reg.sample[SAMPLE_W-1];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                div_next = {div_reg[PROD_W-3:0], b1, b2};
                rem_next = r2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = result;
                    m_last_next   = ent_reg.last;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg      <= ent_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        m_sample_reg <= m_sample_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire

### rtl/pcm_frame_fade_envelope.sv
`timescale 1ns / 1ps
`default_nettype none

// Fade envelope for framed signed 16-bit PCM. The front end takes one request a
// cycle while its two-entry queue has room, tracks frame position, round, fade-in
// and fade-out state and picks a gain for each sample; dropped samples never reach
// the queue. The back end multiplies the sample by the gain numerator and divides
// by the denominator, two quotient bits a cycle; a scaled sample goes through fetch,
// multiply, 12 divide steps and output, an unscaled one through fetch and output,
// one sample at a time; the divider sets the sustained rate. Results wait in an output
// register, so the back end works on the next sample while the sink stalls, holding
// a finished one until the register frees. Registers: ramp_frames (fade-in length)
// at 0x0, fade_out_steps at 0x4, tail_samples at 0x8; write them only while idle.

module pcm_frame_fade_envelope
    import pffe_pkg::*;
#(
    parameter int FRAME_SAMPLES = 160
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // sample[15:0], frame_len[23:16]
    input  wire logic [3:0]  s_tuser,  // final_frame, round_start, later_round, stop_request
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // sample_out[15:0]
    output logic             m_tlast   // frame_end
);

    cfg_t        cfg_reg, cfg_next;
    logic        cfg_write;
    logic [1:0]  reg_index;
    logic        accept;
    logic        q_push;
    entry_t      q_push_entry;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    entry_t      q_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_index)
                REG_FADE_IN:  cfg_next.ramp_frames    = pwdata[6:0];
                REG_FADE_OUT: cfg_next.fade_out_steps = pwdata[4:0];
                REG_TAIL:     cfg_next.tail_samples   = pwdata[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_FADE_IN:  prdata = 32'(cfg_reg.ramp_frames);
            REG_FADE_OUT: prdata = 32'(cfg_reg.fade_out_steps);
            REG_TAIL:     prdata = 32'(cfg_reg.tail_samples);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{ramp_frames: 7'd8, fade_out_steps: 5'd2, tail_samples: 8'd80};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pffe_front #(
        .FRAME_SAMPLES(FRAME_SAMPLES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .accept       (accept),
        .sample       (s_tdata[15:0]),
        .frame_len    (s_tdata[23:16]),
        .final_frame  (s_tuser[0]),
        .round_start  (s_tuser[1]),
        .later_round  (s_tuser[2]),
        .stop_request (s_tuser[3]),
        .push         (q_push),
        .push_entry   (q_push_entry)
    );

    pffe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (q_entry)
    );

    pffe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_sample (m_tdata),
        .m_last   (m_tlast)
    );

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue read while empty");

    a_cfg_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && reg_index == REG_TAIL) |=> cfg_reg.tail_samples == $past(pwdata[7:0]))
        else $error("tail register not written");

endmodule

`default_nettype wire
